>>> hw/rtl/fbmw_pkg.sv
// Shared types and constants for the file block map walker.
// Holds opcodes, walk phases, status codes and the structs passed between
// the top level and the step logic. No dependencies.
package fbmw_pkg;

  // Request opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_RESP   = 2'd2;

  // Walk phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SGL   = 2'd1;
  localparam logic [1:0] PH_DMAP  = 2'd2;
  localparam logic [1:0] PH_DDATA = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REQ    = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  // Fixed slot layout of the inode pointer table
  localparam int unsigned SLOT_IDX_W = 4;
  localparam logic [SLOT_IDX_W-1:0] SINGLE_SLOT = 4'd12;
  localparam logic [SLOT_IDX_W-1:0] DOUBLE_SLOT = 4'd13;
  localparam logic [31:0] DIRECT_COUNT = 32'd12;
  localparam logic [2:0]  MAX_LOG_BS   = 3'd6;

  localparam int unsigned INNER_W  = 14;
  localparam int unsigned SECTOR_W = 39;
  localparam int unsigned OFFSET_W = 9;

  typedef struct packed {
    logic [1:0]         phase;
    logic [INNER_W-1:0] inner;
  } walk_state_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          status;
    logic [31:0]         physical_block;
    logic [SECTOR_W-1:0] sector_number;
    logic [OFFSET_W-1:0] byte_offset;
  } step_result_t;

endpackage

>>> hw/rtl/file_block_map_walker_core.sv
// Top level of the file block map walker: input register, pointer slot
// table, walk state and result register around fbmw_step.
// Depends on fbmw_pkg and fbmw_step.
//
// Usage: requests enter on the in_ channel (valid/stall). Opcode load
// writes in_slot_value into pointer slot in_slot_index (indexes past the
// table are dropped). Opcode lookup maps in_logical_block: direct blocks
// answer with status done at once, indirect blocks answer with a word read
// request (sector and byte offset). The caller fetches that word and sends
// it back with opcode response; this either finishes the walk or issues the
// second request of a double-indirect walk. A new lookup drops any walk in
// progress. Out-of-range blocks answer status beyond.
// A request passes the input register, then the step logic into the
// result register, where its result waits until taken. One request is
// taken every cycle while the receiver keeps out_stall low; when it
// stalls, the result register holds and in_stall rises while both
// registers are full. Reset empties both registers and returns the walk
// to idle with block size code 0; pointer slots hold no defined value
// until loaded. cfg_log_block_size is always ready; the user is to write
// it only while idle, which the block itself does not enforce.
module file_block_map_walker_core #(
  parameter int unsigned SECTOR_BYTES  = 512,
  parameter int unsigned POINTER_SLOTS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [fbmw_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  logic [31:0]                   in_slot_value,
  input  logic [31:0]                   in_logical_block,
  input  logic [31:0]                   in_read_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [31:0]                   out_physical_block,
  output logic [fbmw_pkg::SECTOR_W-1:0] out_sector_number,
  output logic [fbmw_pkg::OFFSET_W-1:0] out_byte_offset,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_log_block_size
);
  import fbmw_pkg::*;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [1:0]            s1_op_r;
  logic [SLOT_IDX_W-1:0] s1_slot_index_r;
  logic [31:0]           s1_slot_value_r;
  logic [31:0]           s1_logical_block_r;
  logic [31:0]           s1_read_word_r;
  logic                  in_take;
  logic                  out_free;
  logic                  s1_go;
  logic [2:0]            log_bs_r;
  walk_state_t           walk_r;
  walk_state_t           walk_nxt;
  logic [31:0]           slots_r [POINTER_SLOTS];
  logic [SLOT_IDX_W-1:0] slot_rd_idx;
  logic [31:0]           slot_rd_data;
  step_result_t          step_res;
  step_result_t          res_r;
  logic                  out_valid_r;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_bs_r <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      log_bs_r <= cfg_log_block_size;
    end
  end

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r            <= in_opcode;
      s1_slot_index_r    <= in_slot_index;
      s1_slot_value_r    <= in_slot_value;
      s1_logical_block_r <= in_logical_block;
      s1_read_word_r     <= in_read_word;
    end
  end

  // Pointer slot table, write on load requests inside the table
  always_ff @(posedge clk) begin
    if (s1_go && s1_op_r == OP_LOAD &&
        {1'b0, s1_slot_index_r} < (SLOT_IDX_W + 1)'(POINTER_SLOTS)) begin
      slots_r[s1_slot_index_r] <= s1_slot_value_r;
    end
  end

  assign slot_rd_data = slots_r[slot_rd_idx];

  fbmw_step #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_step (
    .op             (s1_op_r),
    .logical_block  (s1_logical_block_r),
    .read_word      (s1_read_word_r),
    .log_block_size (log_bs_r),
    .state_cur      (walk_r),
    .slot_rd_data   (slot_rd_data),
    .slot_rd_idx    (slot_rd_idx),
    .state_nxt      (walk_nxt),
    .result         (step_res)
  );

  // Walk state advances with each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= '0;
    end else if (s1_go) begin
      walk_r <= walk_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_res.valid) begin
      res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_physical_block = res_r.physical_block;
  assign out_sector_number  = res_r.sector_number;
  assign out_byte_offset    = res_r.byte_offset;

  // A request result leaves a walk pending
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && step_res.valid && step_res.status == ST_REQ) |=> walk_r.phase != PH_IDLE)
    else $error("request issued but walk is idle");

  // Only request results carry a sector and offset
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_REQ) |->
      (out_sector_number == '0 && out_byte_offset == '0))
    else $error("sector fields set on a non-request result");

  // Only done results carry a physical block
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> out_physical_block == 32'd0)
    else $error("physical block set on a non-done result");

  // A response while idle produces nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_op_r == OP_RESP && walk_r.phase == PH_IDLE) |=> !out_valid)
    else $error("result for a response while idle");

  // Stall on the input only with both the input and the result register full
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room available");

endmodule

>>> hw/rtl/fbmw_step.sv
// Combinational step logic of the file block map walker: decodes one
// registered request, picks the pointer slot to read, forms the result
// and the next walk state. Depends on fbmw_pkg.
module fbmw_step #(
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic [1:0]                     op,
  input  logic [31:0]                    logical_block,
  input  logic [31:0]                    read_word,
  input  logic [2:0]                     log_block_size,
  input  fbmw_pkg::walk_state_t          state_cur,
  input  logic [31:0]                    slot_rd_data,
  output logic [fbmw_pkg::SLOT_IDX_W-1:0] slot_rd_idx,
  output fbmw_pkg::walk_state_t          state_nxt,
  output fbmw_pkg::step_result_t         result
);
  import fbmw_pkg::*;

  localparam int unsigned SectorShift = $clog2(SECTOR_BYTES);
  localparam logic [4:0]  SectorShiftV = 5'(SectorShift);
  localparam logic [15:0] OffMask = 16'(SECTOR_BYTES - 1);

  logic [2:0]          lg;
  logic [14:0]         ppb;
  logic [31:0]         single_lim;
  logic                is_direct;
  logic                is_single;
  logic [31:0]         dbl_rel;
  logic                dbl_in_range;
  logic [INNER_W-1:0]  single_idx;
  logic [INNER_W-1:0]  dbl_hi;
  logic [INNER_W-1:0]  dbl_inner;
  logic [31:0]         req_base;
  logic [INNER_W-1:0]  req_idx;
  logic [15:0]         req_byte;
  logic [4:0]          blk_shift;
  logic [SECTOR_W-1:0] req_sector;
  logic [OFFSET_W-1:0] req_offset;

  // Clamp block size code and derive pointers per block
  assign lg  = (log_block_size > MAX_LOG_BS) ? MAX_LOG_BS : log_block_size;
  assign ppb = 15'd256 << lg;

  // Range decode, the two bounds are compared in parallel
  assign single_lim   = DIRECT_COUNT + 32'(ppb);
  assign is_direct    = logical_block < DIRECT_COUNT;
  assign is_single    = logical_block < single_lim;
  assign dbl_rel      = logical_block - single_lim;
  assign dbl_in_range = (dbl_rel >> (5'd16 + {1'b0, lg, 1'b0})) == 32'd0;
  assign single_idx   = INNER_W'(logical_block - DIRECT_COUNT);
  assign dbl_hi       = INNER_W'(dbl_rel >> (5'd8 + {2'b00, lg}));
  assign dbl_inner    = INNER_W'(dbl_rel) & INNER_W'(ppb - 15'd1);

  // Pick the slot to read for a lookup
  always_comb begin
    if (is_direct) begin
      slot_rd_idx = logical_block[SLOT_IDX_W-1:0];
    end else if (is_single) begin
      slot_rd_idx = SINGLE_SLOT;
    end else begin
      slot_rd_idx = DOUBLE_SLOT;
    end
  end

  // Pick base block and word index for the shared request calculation
  always_comb begin
    if (op == OP_RESP) begin
      req_base = read_word;
      req_idx  = state_cur.inner;
    end else if (is_single) begin
      req_base = slot_rd_data;
      req_idx  = single_idx;
    end else begin
      req_base = slot_rd_data;
      req_idx  = dbl_hi;
    end
  end

  // Sector = base block scaled to sectors + byte / sector size
  assign req_byte  = {req_idx, 2'b00};
  assign blk_shift = 5'd10 + {2'b00, lg};
  always_comb begin
    if (blk_shift >= SectorShiftV) begin
      req_sector = (SECTOR_W'(req_base) << (blk_shift - SectorShiftV))
                   + SECTOR_W'(req_byte >> SectorShift);
    end else begin
      req_sector = SECTOR_W'(req_byte >> SectorShift);
    end
  end
  assign req_offset = OFFSET_W'(req_byte & OffMask);

  // Decode the request and form result and next walk state
  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    case (op)
      OP_LOOKUP: begin
        state_nxt.phase = PH_IDLE;
        result.valid    = 1'b1;
        if (is_direct) begin
          result.status         = ST_DONE;
          result.physical_block = slot_rd_data;
        end else if (is_single) begin
          result.status        = ST_REQ;
          result.sector_number = req_sector;
          result.byte_offset   = req_offset;
          state_nxt.phase      = PH_SGL;
        end else if (dbl_in_range) begin
          result.status        = ST_REQ;
          result.sector_number = req_sector;
          result.byte_offset   = req_offset;
          state_nxt.phase      = PH_DMAP;
          state_nxt.inner      = dbl_inner;
        end else begin
          result.status = ST_BEYOND;
        end
      end
      OP_RESP: begin
        case (state_cur.phase)
          PH_SGL, PH_DDATA: begin
            result.valid          = 1'b1;
            result.status         = ST_DONE;
            result.physical_block = read_word;
            state_nxt.phase       = PH_IDLE;
          end
          PH_DMAP: begin
            result.valid         = 1'b1;
            result.status        = ST_REQ;
            result.sector_number = req_sector;
            result.byte_offset   = req_offset;
            state_nxt.phase      = PH_DDATA;
          end
          default: begin
            result.valid = 1'b0;
          end
        endcase
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

endmodule
